[rtl/sab_pkg.sv]
// sab_pkg: sizes, codes, state encoding and shared types for the skyline
// atlas block allocator. No dependencies; sab_unit and the top-level allocator use it.
`timescale 1ns / 1ps

package sab_pkg;

    // Atlas geometry
    localparam int PAGES   = 2;
    localparam int COLUMNS = 256;
    localparam int ROWS    = 256;

    // Derived widths
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int HGT_W  = $clog2(ROWS + 1);
    localparam int HA_W   = PAGE_W + COL_W;

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Result status codes
    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FULL = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD,
        ST_FWD_END,
        ST_BWD,
        ST_BWD_END,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Result of one step of the shared max/compare unit
    typedef struct packed {
        logic [HGT_W-1:0] acc;
        logic [HGT_W-1:0] top;
        logic             take;
    } t_unit_res;

endpackage

[rtl/sab_ram.sv]
// sab_ram: generic simple dual-port RAM, one write and one registered read port.
// No package dependency.
`timescale 1ns / 1ps

module sab_ram #(
    parameter int AW = 8,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sab_unit.sv]
// sab_unit: shared max/compare unit, one column step per cycle.
// Depends on sab_pkg for widths and the result struct.
`timescale 1ns / 1ps

module sab_unit (
    input  logic [sab_pkg::HGT_W-1:0] i_acc,
    input  logic [sab_pkg::HGT_W-1:0] i_col,
    input  logic                      i_restart,
    input  logic [sab_pkg::HGT_W-1:0] i_other,
    input  logic [sab_pkg::HGT_W-1:0] i_best,
    output sab_pkg::t_unit_res        o_res
);

    logic [sab_pkg::HGT_W-1:0] acc_nxt;
    logic [sab_pkg::HGT_W-1:0] top;

    // running block max, restarted at a block boundary
    always_comb begin
        if (i_restart || (i_col > i_acc)) begin
            acc_nxt = i_col;
        end else begin
            acc_nxt = i_acc;
        end
    end

    // window top combines the two partial maxima
    assign top = (i_other > acc_nxt) ? i_other : acc_nxt;

    // scanning right to left, ties move the winner left
    always_comb begin
        o_res.acc  = acc_nxt;
        o_res.top  = top;
        o_res.take = (top <= i_best);
    end

endmodule

[rtl/skyline_atlas_block_allocator.sv]
// Skyline atlas allocator: per page, a forward pass builds block prefix maxima,
// a backward pass forms window maxima and picks the leftmost lowest start.
// The pages are tried in turn until one fits; then the columns are raised and the
// result word is handed over. One word at a time.
// Clear action and reset both run a pass over all 2**(PAGE_W+COL_W) entries (512 here)
// of the height memory; no word is accepted during it.
`timescale 1ns / 1ps

module skyline_atlas_block_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [8:0] i_rect_width,
    input  logic [8:0] i_rect_height,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_page,
    output logic [7:0] o_pos_x,
    output logic [7:0] o_pos_y,
    output logic       o_status
);

    localparam int PAGE_W = sab_pkg::PAGE_W;
    localparam int COL_W  = sab_pkg::COL_W;
    localparam int HGT_W  = sab_pkg::HGT_W;
    localparam int HA_W   = sab_pkg::HA_W;

    sab_pkg::t_state r_state, n_state;

    logic [HA_W-1:0]   r_clr_idx;
    logic              r_clr_reply;
    logic [COL_W-1:0]  r_w_m1;
    logic [HGT_W-1:0]  r_h;
    logic [PAGE_W-1:0] r_page;
    logic [COL_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_off;
    logic [COL_W-1:0]  r_rem;

    logic              r_s1_vld;
    logic              r_s1_bwd;
    logic [COL_W-1:0]  r_s1_idx;
    logic              r_s1_first;
    logic              r_s1_win;

    logic [HGT_W-1:0]  r_acc;
    logic [HGT_W-1:0]  r_best;
    logic [COL_W-1:0]  r_best_x;
    logic              r_res_full;
    logic              r_res_place;

    logic              r_out_valid;
    logic              r_out_page;
    logic [7:0]        r_out_x;
    logic [7:0]        r_out_y;
    logic              r_out_status;

    logic              in_acc;
    logic              req_bad;
    logic              last_col;
    logic              last_page;
    logic              out_free;
    logic              fit;
    logic              bwd_end_flag;
    logic              bwd_win;
    logic [HGT_W-1:0]  new_height;

    logic              hm_we;
    logic [HA_W-1:0]   hm_waddr;
    logic [HGT_W-1:0]  hm_wdata;
    logic [HA_W-1:0]   hm_raddr;
    logic [HGT_W-1:0]  hm_rdata;
    logic              pm_we;
    logic [COL_W-1:0]  pm_raddr;
    logic [HGT_W-1:0]  pm_rdata;
    logic [HGT_W-1:0]  unit_other;

    sab_pkg::t_unit_res unit_res;

    // status decodes
    always_comb begin
        in_acc    = (r_state == sab_pkg::ST_IDLE) && i_valid;
        req_bad   = (i_rect_width == 9'd0) || (i_rect_height == 9'd0) ||
                    (32'(i_rect_width) > sab_pkg::COLUMNS) ||
                    (32'(i_rect_height) > sab_pkg::ROWS);
        last_col  = (r_idx == COL_W'(sab_pkg::COLUMNS - 1));
        last_page = (r_page == PAGE_W'(sab_pkg::PAGES - 1));
        out_free  = !r_out_valid || !i_stall;
        fit       = ({1'b0, r_best} + {1'b0, r_h}) <= (HGT_W + 1)'(sab_pkg::ROWS);
        new_height = r_best + r_h;
        bwd_end_flag = last_col || (r_off == '0);
        bwd_win   = ({1'b0, r_idx} + {1'b0, r_w_m1}) <= (COL_W + 1)'(sab_pkg::COLUMNS - 1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sab_pkg::ST_CLEAR: begin
                if (&r_clr_idx) begin
                    n_state = r_clr_reply ? sab_pkg::ST_DONE : sab_pkg::ST_IDLE;
                end
            end
            sab_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_action == sab_pkg::ACT_CLEAR) begin
                        n_state = sab_pkg::ST_CLEAR;
                    end else if (req_bad) begin
                        n_state = sab_pkg::ST_DONE;
                    end else begin
                        n_state = sab_pkg::ST_FWD;
                    end
                end
            end
            sab_pkg::ST_FWD: begin
                if (last_col) begin
                    n_state = sab_pkg::ST_FWD_END;
                end
            end
            sab_pkg::ST_FWD_END: n_state = sab_pkg::ST_BWD;
            sab_pkg::ST_BWD: begin
                if (r_idx == '0) begin
                    n_state = sab_pkg::ST_BWD_END;
                end
            end
            sab_pkg::ST_BWD_END: n_state = sab_pkg::ST_DECIDE;
            sab_pkg::ST_DECIDE: begin
                if (fit) begin
                    n_state = sab_pkg::ST_WRITE;
                end else if (last_page) begin
                    n_state = sab_pkg::ST_DONE;
                end else begin
                    n_state = sab_pkg::ST_FWD;
                end
            end
            sab_pkg::ST_WRITE: begin
                if (r_rem == '0) begin
                    n_state = sab_pkg::ST_DONE;
                end
            end
            sab_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = sab_pkg::ST_IDLE;
                end
            end
            default: n_state = sab_pkg::ST_CLEAR;
        endcase
    end

    // memory port control
    always_comb begin
        o_stall    = (r_state != sab_pkg::ST_IDLE);
        hm_we      = (r_state == sab_pkg::ST_CLEAR) || (r_state == sab_pkg::ST_WRITE);
        hm_waddr   = (r_state == sab_pkg::ST_CLEAR) ? r_clr_idx : {r_page, r_idx};
        hm_wdata   = (r_state == sab_pkg::ST_CLEAR) ? '0 : new_height;
        hm_raddr   = {r_page, r_idx};
        pm_we      = r_s1_vld && !r_s1_bwd;
        pm_raddr   = r_idx + r_w_m1;
        unit_other = r_s1_bwd ? pm_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sab_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // column heights, page-major
    sab_ram #(
        .AW (HA_W),
        .DW (HGT_W)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (hm_we),
        .i_waddr (hm_waddr),
        .i_wdata (hm_wdata),
        .i_raddr (hm_raddr),
        .o_rdata (hm_rdata)
    );

    // block prefix maxima of the page under scan
    sab_ram #(
        .AW (COL_W),
        .DW (HGT_W)
    ) u_prefix (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (r_s1_idx),
        .i_wdata (unit_res.acc),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    sab_unit u_unit (
        .i_acc     (r_acc),
        .i_col     (hm_rdata),
        .i_restart (r_s1_first),
        .i_other   (unit_other),
        .i_best    (r_best),
        .o_res     (unit_res)
    );

    // clear sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b0;
        end else if (in_acc && (i_action == sab_pkg::ACT_CLEAR)) begin
            r_clr_idx   <= '0;
            r_clr_reply <= 1'b1;
        end else if (r_state == sab_pkg::ST_CLEAR) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // scan stage after the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == sab_pkg::ST_FWD) || (r_state == sab_pkg::ST_BWD);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bwd   <= (r_state == sab_pkg::ST_BWD);
        r_s1_idx   <= r_idx;
        r_s1_first <= (r_state == sab_pkg::ST_BWD) ? bwd_end_flag : (r_off == '0);
        r_s1_win   <= bwd_win;
        if (r_s1_vld) begin
            r_acc <= unit_res.acc;
        end
    end

    // request fields, column walk and winner tracking
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sab_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_w_m1      <= COL_W'(i_rect_width - 9'd1);
                    r_h         <= HGT_W'(i_rect_height);
                    r_page      <= '0;
                    r_idx       <= '0;
                    r_off       <= '0;
                    r_best      <= HGT_W'(sab_pkg::ROWS);
                    r_res_full  <= (i_action == sab_pkg::ACT_ALLOC);
                    r_res_place <= 1'b0;
                end
            end
            sab_pkg::ST_FWD: begin
                r_off <= (r_off == r_w_m1) ? '0 : r_off + 1'b1;
                if (!last_col) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            sab_pkg::ST_BWD: begin
                r_off <= (r_off == '0) ? r_w_m1 : r_off - 1'b1;
                if (r_idx != '0) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            sab_pkg::ST_DECIDE: begin
                if (fit) begin
                    r_idx       <= r_best_x;
                    r_rem       <= r_w_m1;
                    r_res_full  <= 1'b0;
                    r_res_place <= 1'b1;
                end else if (last_page) begin
                    r_res_full  <= 1'b1;
                    r_res_place <= 1'b0;
                end else begin
                    r_page <= r_page + 1'b1;
                    r_idx  <= '0;
                    r_off  <= '0;
                    r_best <= HGT_W'(sab_pkg::ROWS);
                end
            end
            sab_pkg::ST_WRITE: begin
                r_idx <= r_idx + 1'b1;
                r_rem <= r_rem - 1'b1;
            end
            default: begin
            end
        endcase
        // winner update from the backward scan stage
        if (r_s1_vld && r_s1_bwd && r_s1_win && unit_res.take) begin
            r_best   <= unit_res.top;
            r_best_x <= r_s1_idx;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == sab_pkg::ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == sab_pkg::ST_DONE) && out_free) begin
            r_out_page   <= r_res_place ? r_page[0] : 1'b0;
            r_out_x      <= r_res_place ? 8'(r_best_x) : 8'd0;
            r_out_y      <= r_res_place ? 8'(r_best) : 8'd0;
            r_out_status <= r_res_full ? sab_pkg::STS_FULL : sab_pkg::STS_OK;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_page   = r_out_page;
    assign o_pos_x  = r_out_x;
    assign o_pos_y  = r_out_y;
    assign o_status = r_out_status;

`ifndef SYNTHESIS
    // raised columns stay inside the page
    a_write_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sab_pkg::ST_WRITE) |->
        (({1'b0, r_best_x} + {1'b0, r_w_m1}) <= (COL_W + 1)'(sab_pkg::COLUMNS - 1)))
        else $error("placement runs past the last column");

    // raised height never exceeds the page
    a_write_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sab_pkg::ST_WRITE) |->
        (({1'b0, r_best} + {1'b0, r_h}) <= (HGT_W + 1)'(sab_pkg::ROWS)))
        else $error("placement exceeds page height");

    // a new word only comes out of the hand-over state
    a_word_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == sab_pkg::ST_DONE))
        else $error("result word raised outside hand-over");
`endif

endmodule
